// File: hdl/eia_pkg.sv
// Shared constants and control types for the expiring index allocator.
`default_nettype none

package eia_pkg;

  localparam int unsigned TimeW    = 63;
  localparam int unsigned SlotW    = 10;
  localparam int unsigned ActiveW  = 11;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned EntryW   = TimeW + 1;

  localparam logic [CmdW-1:0] CMD_BORROW  = 2'd0;
  localparam logic [CmdW-1:0] CMD_REFRESH = 2'd1;
  localparam logic [CmdW-1:0] CMD_QUERY   = 2'd2;
  localparam logic [CmdW-1:0] CMD_RETURN  = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_EXPIRY = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE = 1'd1;

  localparam logic [TimeW-1:0]   STAMP_FREE     = {TimeW{1'b1}};
  localparam logic [ActiveW-1:0] ACTIVE_RESET   = 11'd1024;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;
    logic clr;
    logic scan;
    logic access;
    logic resp;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic scan_done;
  } dp_stat_t;

endpackage : eia_pkg

`default_nettype wire

// File: hdl/eia_ctrl.sv
// Control state machine: clearing pass, borrow scan and single-entry access.
`default_nettype none

module eia_ctrl
  import eia_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [CmdW-1:0] cmd_i,
  input  wire dp_stat_t        stat_i,
  output logic                 busy_o,
  output ctl_cmd_t             ctl_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_ACCESS = 3'd3;
  localparam logic [2:0] ST_RESP   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ctl_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          ctl_o.latch = 1'b1;
          state_d     = (cmd_i == CMD_BORROW) ? ST_SCAN : ST_ACCESS;
        end
      end
      ST_SCAN: begin
        ctl_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_ACCESS: begin
        ctl_o.access = 1'b1;
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        ctl_o.resp = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule : eia_ctrl

`default_nettype wire

// File: hdl/eia_datapath.sv
// Datapath: configuration registers, entry memory, scan pointer and result registers.
`default_nettype none

module eia_datapath
  import eia_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ctl_cmd_t           ctl_i,
  output dp_stat_t                stat_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [TimeW-1:0]   cfg_wdata_i,
  input  wire logic [CmdW-1:0]    cmd_i,
  input  wire logic [TimeW-1:0]   now_i,
  input  wire logic [SlotW-1:0]   slot_i,
  output logic                    result_valid_o,
  output logic                    ok_o,
  output logic [SlotW-1:0]        granted_slot_o,
  output logic                    reclaimed_o,
  output logic                    live_o
);

  localparam int unsigned IdxW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CntW = (IdxW + 1 > ActiveW) ? IdxW + 1 : ActiveW;
  localparam logic [CntW-1:0] DepthC   = CntW'(POOL_DEPTH);
  localparam logic [IdxW-1:0] LastIdxC = IdxW'(POOL_DEPTH - 1);

  // Configuration registers
  logic [TimeW-1:0]   expiry_q;
  logic [ActiveW-1:0] active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q <= '0;
      active_q <= ACTIVE_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_EXPIRY) begin
        expiry_q <= cfg_wdata_i;
      end else if (cfg_idx_i == CFG_ACTIVE) begin
        active_q <= cfg_wdata_i[ActiveW-1:0];
      end
    end
  end

  logic [CntW-1:0] active_ext, size;
  assign active_ext = {{(CntW-ActiveW){1'b0}}, active_q};
  assign size       = (active_ext > DepthC) ? DepthC : active_ext;

  // Latched item
  logic [CmdW-1:0]  cmd_q;
  logic [TimeW-1:0] now_q, thr_q;
  logic             ge_q;
  logic [IdxW-1:0]  slot_idx_q;
  logic             in_rng_q;
  logic [IdxW-1:0]  last_grant_q;
  logic [IdxW-1:0]  ptr_q, ptr_d;
  logic [CntW-1:0]  iss_cnt_q;
  logic             rd_valid_q;
  logic [IdxW-1:0]  ev_addr_q;
  logic [IdxW-1:0]  clr_ptr_q;

  logic [CntW-1:0] slot_ext, lg_ext, ptr_ext, ptr_inc;
  assign slot_ext = {{(CntW-SlotW){1'b0}}, slot_i};
  assign lg_ext   = {{(CntW-IdxW){1'b0}}, last_grant_q};
  assign ptr_ext  = {{(CntW-IdxW){1'b0}}, ptr_q};
  assign ptr_inc  = ptr_ext + CntW'(1);

  // Entry memory: {in use, stamp}
  logic [EntryW-1:0] mem [POOL_DEPTH];
  logic [EntryW-1:0] rdata_q;
  logic              mem_we;
  logic [IdxW-1:0]   waddr, raddr;
  logic [EntryW-1:0] wdata;

  logic             rd_used;
  logic [TimeW-1:0] rd_stamp;
  logic             rd_expired;
  assign rd_used    = rdata_q[EntryW-1];
  assign rd_stamp   = rdata_q[TimeW-1:0];
  assign rd_expired = ge_q && (thr_q > rd_stamp);

  logic issue, hit, fail;
  assign issue = ctl_i.scan && (iss_cnt_q != size);
  assign hit   = ctl_i.scan && rd_valid_q && (!rd_used || rd_expired);
  assign fail  = ctl_i.scan && (iss_cnt_q == size) && !hit;

  assign stat_o.clr_last  = (clr_ptr_q == LastIdxC);
  assign stat_o.scan_done = hit || fail;

  always_comb begin
    if (issue) begin
      ptr_d = (ptr_inc == size) ? '0 : ptr_inc[IdxW-1:0];
    end else begin
      ptr_d = ptr_q;
    end
    if (ctl_i.latch) begin
      ptr_d = (lg_ext < size) ? last_grant_q : '0;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = slot_idx_q;
    wdata  = {1'b1, now_q};
    raddr  = ctl_i.scan ? ptr_q : slot_idx_q;
    priority if (ctl_i.clr) begin
      mem_we = 1'b1;
      waddr  = clr_ptr_q;
      wdata  = {1'b0, STAMP_FREE};
    end else if (hit) begin
      mem_we = 1'b1;
      waddr  = ev_addr_q;
    end else if (ctl_i.resp && in_rng_q && (cmd_q == CMD_REFRESH)) begin
      mem_we = 1'b1;
    end else if (ctl_i.resp && in_rng_q && (cmd_q == CMD_RETURN)) begin
      mem_we = 1'b1;
      wdata  = {1'b0, STAMP_FREE};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (ctl_i.scan || ctl_i.access) begin
      rdata_q <= mem[raddr];
    end
  end

  // Item latch, no reset needed on payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q      <= cmd_i;
      now_q      <= now_i;
      thr_q      <= now_i - expiry_q;
      ge_q       <= (now_i >= expiry_q);
      slot_idx_q <= slot_ext[IdxW-1:0];
      in_rng_q   <= (slot_ext < size);
    end
    ev_addr_q <= ptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_ptr_q    <= '0;
      last_grant_q <= '0;
      ptr_q        <= '0;
      iss_cnt_q    <= '0;
      rd_valid_q   <= 1'b0;
    end else begin
      if (ctl_i.clr) begin
        clr_ptr_q <= clr_ptr_q + IdxW'(1);
      end
      if (hit) begin
        last_grant_q <= ev_addr_q;
      end
      ptr_q <= ptr_d;
      if (ctl_i.latch) begin
        iss_cnt_q <= '0;
      end else if (issue) begin
        iss_cnt_q <= iss_cnt_q + CntW'(1);
      end
      rd_valid_q <= issue;
    end
  end

  // Result registers
  logic            res_valid_q;
  logic            ok_q, reclaimed_q, live_q;
  logic [SlotW-1:0] granted_q;
  logic [CntW-1:0]  ev_ext;
  assign ev_ext = {{(CntW-IdxW){1'b0}}, ev_addr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= hit || fail || ctl_i.resp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit) begin
      ok_q        <= 1'b1;
      granted_q   <= ev_ext[SlotW-1:0];
      reclaimed_q <= rd_used;
      live_q      <= 1'b0;
    end else if (fail) begin
      ok_q        <= 1'b0;
      granted_q   <= '0;
      reclaimed_q <= 1'b0;
      live_q      <= 1'b0;
    end else if (ctl_i.resp) begin
      ok_q        <= in_rng_q;
      granted_q   <= '0;
      reclaimed_q <= 1'b0;
      live_q      <= in_rng_q && (cmd_q == CMD_QUERY) && rd_used && !rd_expired;
    end
  end

  assign result_valid_o = res_valid_q;
  assign ok_o           = ok_q;
  assign granted_slot_o = granted_q;
  assign reclaimed_o    = reclaimed_q;
  assign live_o         = live_q;

endmodule : eia_datapath

`default_nettype wire

// File: hdl/expiring_index_allocator.sv
// Refresh, query and return pass through the latch, access and response states; start is only taken while idle.
// Borrow: one entry read per cycle from the last grant; the result follows the first free or
//   expired entry found, or reports failure once every entry within the active size has been read.
// Reset: a clearing pass frees every entry; busy stays high meanwhile.
// Results are a one-cycle strobe on result_valid_o; the receiver cannot stall.
`default_nettype none

module expiring_index_allocator
  import eia_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [TimeW-1:0]   cfg_wdata_i,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [CmdW-1:0]    cmd_i,
  input  wire logic [TimeW-1:0]   now_i,
  input  wire logic [SlotW-1:0]   slot_i,
  output logic                    result_valid_o,
  output logic                    ok_o,
  output logic [SlotW-1:0]        granted_slot_o,
  output logic                    reclaimed_o,
  output logic                    live_o
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  eia_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (cmd_i),
    .stat_i  (stat),
    .busy_o  (busy),
    .ctl_o   (ctl)
  );

  eia_datapath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd_i),
    .now_i          (now_i),
    .slot_i         (slot_i),
    .result_valid_o (result_valid_o),
    .ok_o           (ok_o),
    .granted_slot_o (granted_slot_o),
    .reclaimed_o    (reclaimed_o),
    .live_o         (live_o)
  );

endmodule : expiring_index_allocator

`default_nettype wire
